### rtl/mers_pkg.sv
package mers_pkg;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;
    localparam logic [1:0] FUNC_CANCEL = 2'd3;

    localparam logic [1:0] KIND_PDN   = 2'd0;
    localparam logic [1:0] KIND_BOOT  = 2'd1;
    localparam logic [1:0] KIND_RAMP  = 2'd2;
    localparam logic [1:0] KIND_FINAL = 2'd3;

    // pass that the sequencer runs over the channel table
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;
    localparam logic [1:0] MODE_FINAL = 2'd2;

    localparam logic [15:0] BOOT_HOLD_RST = 16'd5000;

    typedef struct packed {
        logic        en;
        logic [4:0]  beq;
        logic [4:0]  req;
        logic [2:0]  bfg;
        logic [2:0]  rfg;
        logic [2:0]  bbias;
        logic [2:0]  rbias;
        logic [15:0] step;
        logic [15:0] delay;
    } t_chan;

    typedef struct packed {
        logic [3:0] ch;
        logic [1:0] kind;
        logic [7:0] eqc;
        logic [6:0] pg;
        logic [2:0] bias;
    } t_res;

    typedef struct packed {
        logic       load;
        logic       cancel;
        logic       tick;
        logic       advance;
        logic       flush;
        logic [1:0] mode;
    } t_cmd;

    typedef struct packed {
        logic ramp_busy;
        logic emit;
        logic hold_valid;
        logic out_free;
    } t_sts;

    // level number to position in the level sequence, unknown levels go to 0
    function automatic logic [4:0] seq_idx(input logic [4:0] level);
        logic [4:0] idx;
        if (level <= 5'd2) begin
            idx = level;
        end else if (level inside {[5'd5:5'd19]}) begin
            idx = level - 5'd2;
        end else begin
            idx = 5'd0;
        end
        return idx;
    endfunction

    // {bypass, stage1, stage2}
    function automatic logic [7:0] seq_ctrl(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = {1'b1, 4'd0,  3'd0};
            5'd1:    c = {1'b1, 4'd1,  3'd0};
            5'd2:    c = {1'b1, 4'd3,  3'd0};
            5'd3:    c = {1'b0, 4'd0,  3'd0};
            5'd4:    c = {1'b0, 4'd1,  3'd0};
            5'd5:    c = {1'b0, 4'd2,  3'd0};
            5'd6:    c = {1'b0, 4'd3,  3'd0};
            5'd7:    c = {1'b0, 4'd4,  3'd0};
            5'd8:    c = {1'b0, 4'd5,  3'd1};
            5'd9:    c = {1'b0, 4'd6,  3'd1};
            5'd10:   c = {1'b0, 4'd8,  3'd1};
            5'd11:   c = {1'b0, 4'd10, 3'd1};
            5'd12:   c = {1'b0, 4'd10, 3'd2};
            5'd13:   c = {1'b0, 4'd11, 3'd3};
            5'd14:   c = {1'b0, 4'd12, 3'd4};
            5'd15:   c = {1'b0, 4'd13, 3'd5};
            5'd16:   c = {1'b0, 4'd14, 3'd6};
            5'd17:   c = {1'b0, 4'd15, 3'd7};
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // profile field in bits 6:3
    function automatic logic [6:0] seq_prof(input logic [4:0] idx);
        logic [3:0] p;
        if (idx <= 5'd2) begin
            p = 4'd0;
        end else if (idx inside {[5'd3:5'd5]}) begin
            p = 4'd1;
        end else if (idx inside {[5'd6:5'd7]}) begin
            p = 4'd3;
        end else if (idx inside {[5'd8:5'd11]}) begin
            p = 4'd7;
        end else begin
            p = 4'd15;
        end
        return {p, 3'b000};
    endfunction

    // move n codes from 'from' toward 'to', stopping at 'to'
    function automatic logic [4:0] walk_to(input logic [4:0] from, input logic [4:0] to,
                                           input logic [5:0] n);
        logic [6:0] up;
        logic [4:0] gap;
        logic [4:0] w;
        up  = {2'b00, from} + {1'b0, n};
        gap = from - to;
        if (to >= from) begin
            w = (up > {2'b00, to}) ? to : up[4:0];
        end else begin
            w = ({1'b0, gap} <= n) ? to : (from - n[4:0]);
        end
        return w;
    endfunction

    function automatic logic [4:0] code_gap(input logic [4:0] a, input logic [4:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### rtl/mers_ctrl.sv
module mers_ctrl
    import mers_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [1:0]                 i_func,
    output logic                       o_ready,
    input  t_sts                       i_sts,
    output t_cmd                       o_cmd,
    output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] o_idx
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_CHANNELS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_mode, n_mode;
    logic             r_running, n_running;
    logic             acc;
    logic             stall;

    assign acc     = i_valid && (r_state == ST_IDLE);
    assign o_ready = (r_state == ST_IDLE);
    assign o_idx   = r_idx;
    // a new result needs the held one to move out first
    assign stall   = i_sts.emit && i_sts.hold_valid && !i_sts.out_free;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_mode    = r_mode;
        n_running = r_running;
        o_cmd     = '0;
        o_cmd.mode = r_mode;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (i_func)
                        FUNC_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        FUNC_CANCEL: begin
                            o_cmd.cancel = 1'b1;
                            n_running    = 1'b0;
                        end
                        FUNC_START: begin
                            n_mode    = MODE_START;
                            n_running = 1'b1;
                            n_idx     = '0;
                            n_state   = ST_SCAN;
                        end
                        FUNC_TICK: begin
                            o_cmd.tick = 1'b1;
                            if (r_running) begin
                                n_idx   = '0;
                                n_state = ST_SCAN;
                                if (i_sts.ramp_busy) begin
                                    n_mode = MODE_STEP;
                                end else begin
                                    n_mode    = MODE_FINAL;
                                    n_running = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    o_cmd.advance = 1'b1;
                    if (r_idx == LAST) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_sts.hold_valid) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_mode    <= MODE_START;
            r_running <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_mode    <= n_mode;
            r_running <= n_running;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= LAST))
        else $error("channel index beyond table");

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_func == FUNC_START)) |=>
            ((r_state == ST_SCAN) && (r_idx == '0) && (r_mode == MODE_START) && r_running))
        else $error("start request did not begin a scan");

    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |=> (r_state == ST_IDLE))
        else $error("flush did not return to idle");
`endif

endmodule

### rtl/mers_dp.sv
module mers_dp
    import mers_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] i_idx,
    input  logic [3:0]  i_channel,
    input  logic        i_enabled,
    input  logic [4:0]  i_boot_eq_level,
    input  logic [4:0]  i_run_eq_level,
    input  logic [2:0]  i_boot_flat_gain,
    input  logic [2:0]  i_run_flat_gain,
    input  logic [2:0]  i_boot_bias,
    input  logic [2:0]  i_run_bias,
    input  logic [15:0] i_step_ms,
    input  logic [15:0] i_delay_ms,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_sts        o_sts,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_channel_out,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_eq_control,
    output logic [6:0]  o_eq_profile_gain,
    output logic [2:0]  o_bias_code,
    output logic        o_last
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_chan       r_tab  [NUM_CHANNELS];
    logic [5:0]  r_step [NUM_CHANNELS];
    logic [31:0] r_dl   [NUM_CHANNELS];
    logic [31:0] r_time;
    logic [15:0] r_hold_ms;

    t_res        r_hold;
    logic        r_hold_valid;
    t_res        r_out;
    logic        r_out_valid;
    logic        r_out_last;

    t_chan       c;
    logic [5:0]  s;
    logic [31:0] dl;
    logic [4:0]  bi, ri;
    logic [4:0]  maxd, d_eq, d_fg, d_bias;
    logic [31:0] since;
    logic        due;
    logic        done;
    logic [31:0] arm;
    logic [4:0]  eqi;
    logic [2:0]  fg, bias;
    t_res        res;
    logic        emit;
    logic        any;
    logic        out_free;
    logic        load_ok;

    assign c  = r_tab[i_idx];
    assign s  = r_step[i_idx];
    assign dl = r_dl[i_idx];
    assign bi = seq_idx(c.beq);
    assign ri = seq_idx(c.req);

    assign d_eq   = code_gap(ri, bi);
    assign d_fg   = code_gap({2'b00, c.rfg}, {2'b00, c.bfg});
    assign d_bias = code_gap({2'b00, c.rbias}, {2'b00, c.bbias});

    always_comb begin
        maxd = d_eq;
        if (d_fg > maxd) maxd = d_fg;
        if (d_bias > maxd) maxd = d_bias;
    end

    // due once time_now has reached the deadline, modulo 2^32
    assign since = r_time - dl;
    assign due   = !since[31];
    assign done  = (s >= {1'b0, maxd});
    assign arm   = r_time + {16'd0, r_hold_ms} + {16'd0, c.delay} + {16'd0, c.step};

    always_comb begin
        res      = '0;
        res.ch   = 4'(i_idx);
        emit     = 1'b0;
        eqi      = bi;
        fg       = c.bfg;
        bias     = c.bbias;
        res.kind = KIND_PDN;
        case (i_cmd.mode)
            MODE_START: begin
                emit     = 1'b1;
                res.kind = c.en ? KIND_BOOT : KIND_PDN;
            end
            MODE_STEP: begin
                emit     = (s != 6'd0) && due;
                res.kind = KIND_RAMP;
                eqi      = walk_to(bi, ri, s);
                fg       = 3'(walk_to({2'b00, c.bfg}, {2'b00, c.rfg}, s));
                bias     = 3'(walk_to({2'b00, c.bbias}, {2'b00, c.rbias}, s));
            end
            MODE_FINAL: begin
                emit     = c.en;
                res.kind = KIND_FINAL;
                eqi      = ri;
                fg       = c.rfg;
                bias     = c.rbias;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        // power-down results carry zero settings
        if (res.kind != KIND_PDN) begin
            res.eqc  = seq_ctrl(eqi);
            res.pg   = seq_prof(eqi) | {4'd0, fg};
            res.bias = bias;
        end
    end

    always_comb begin
        any = 1'b0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            any = any | (r_step[k] != 6'd0);
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign load_ok  = i_cmd.load && ({1'b0, i_channel} < 5'(NUM_CHANNELS));

    assign o_sts.ramp_busy  = any;
    assign o_sts.emit       = emit;
    assign o_sts.hold_valid = r_hold_valid;
    assign o_sts.out_free   = out_free;

    // channel table, only the enable bit needs a reset value
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_tab[i_channel[IDX_W-1:0]] <= '{en: i_enabled, beq: i_boot_eq_level,
                req: i_run_eq_level, bfg: i_boot_flat_gain, rfg: i_run_flat_gain,
                bbias: i_boot_bias, rbias: i_run_bias, step: i_step_ms,
                delay: i_delay_ms};
        end
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_tab[k].en <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_step[k] <= 6'd0;
            end
        end else if (i_cmd.cancel) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_step[k] <= 6'd0;
            end
        end else if (i_cmd.advance) begin
            if (i_cmd.mode == MODE_START) begin
                r_step[i_idx] <= c.en ? 6'd1 : 6'd0;
            end else if ((i_cmd.mode == MODE_STEP) && emit) begin
                r_step[i_idx] <= done ? 6'd0 : (s + 6'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            if ((i_cmd.mode == MODE_START) && c.en) begin
                r_dl[i_idx] <= arm;
            end else if ((i_cmd.mode == MODE_STEP) && emit && !done) begin
                r_dl[i_idx] <= dl + {16'd0, c.step};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= 32'd0;
            r_hold_ms <= BOOT_HOLD_RST;
        end else begin
            if (i_cmd.tick) begin
                r_time <= r_time + 32'd1;
            end
            if (i_cfg_we) begin
                r_hold_ms <= i_cfg_wdata;
            end
        end
    end

    // one result is held back so the last one of a request can be marked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.advance && emit) begin
                r_hold_valid <= 1'b1;
                if (r_hold_valid) begin
                    r_out_valid <= 1'b1;
                end else if (i_ready) begin
                    r_out_valid <= 1'b0;
                end
            end else if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance && emit) begin
            r_hold <= res;
            if (r_hold_valid) begin
                r_out      <= r_hold;
                r_out_last <= 1'b0;
            end
        end else if (i_cmd.flush) begin
            r_out      <= r_hold;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_channel_out     = r_out.ch;
    assign o_kind            = r_out.kind;
    assign o_eq_control      = r_out.eqc;
    assign o_eq_profile_gain = r_out.pg;
    assign o_bias_code       = r_out.bias;
    assign o_last            = r_out_last;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.advance && emit && r_hold_valid) |-> out_free)
        else $error("held result pushed into a busy output register");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (!r_hold_valid && r_out_valid && r_out_last))
        else $error("flush did not present the final result");

    a_cancel_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cancel |=> !any)
        else $error("cancel left a channel ramping");
`endif

endmodule

### rtl/multichannel_eq_ramp_scheduler.sv
// channel   direction  handshake             payload
// request   in         i_valid / o_ready     i_func, i_channel, descriptor fields
// result    out        o_valid / i_ready     o_channel_out .. o_bias_code, o_last
// config    in         i_cfg_we              i_cfg_wdata (boot hold in ms)
//
// load, cancel and an idle tick leave the block idle; start and a tick while ramping
// walk the channel table one entry per cycle while the walk is not stalled
// an entry with a result stalls the walk while the held result waits on a full output
// synchronous active-low reset clears the enables, ramp counters and clock
// one held result plus the output register sit between the walk and i_ready
module multichannel_eq_ramp_scheduler
    import mers_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_channel,
    input  logic        i_enabled,
    input  logic [4:0]  i_boot_eq_level,
    input  logic [4:0]  i_run_eq_level,
    input  logic [2:0]  i_boot_flat_gain,
    input  logic [2:0]  i_run_flat_gain,
    input  logic [2:0]  i_boot_bias,
    input  logic [2:0]  i_run_bias,
    input  logic [15:0] i_step_ms,
    input  logic [15:0] i_delay_ms,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_channel_out,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_eq_control,
    output logic [6:0]  o_eq_profile_gain,
    output logic [2:0]  o_bias_code,
    output logic        o_last
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_cmd             cmd;
    t_sts             sts;
    logic [IDX_W-1:0] idx;

    mers_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idx   (idx)
    );

    mers_dp #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_idx             (idx),
        .i_channel         (i_channel),
        .i_enabled         (i_enabled),
        .i_boot_eq_level   (i_boot_eq_level),
        .i_run_eq_level    (i_run_eq_level),
        .i_boot_flat_gain  (i_boot_flat_gain),
        .i_run_flat_gain   (i_run_flat_gain),
        .i_boot_bias       (i_boot_bias),
        .i_run_bias        (i_run_bias),
        .i_step_ms         (i_step_ms),
        .i_delay_ms        (i_delay_ms),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_channel_out     (o_channel_out),
        .o_kind            (o_kind),
        .o_eq_control      (o_eq_control),
        .o_eq_profile_gain (o_eq_profile_gain),
        .o_bias_code       (o_bias_code),
        .o_last            (o_last)
    );

endmodule
